@@ src/pfau_pkg.sv @@
package pfau_pkg;

  localparam int unsigned MOD_W = 31;
  localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;
  // One quotient bit per cycle over a full 64-bit dividend.
  localparam logic [6:0] DIV_STEPS = 7'd64;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_NEG = 3'd4;
  localparam logic [2:0] MODE_POW = 3'd5;
  localparam logic [2:0] MODE_RED = 3'd6;

  typedef struct packed {
    logic [2:0]        mode;
    logic [30:0]       lhs;
    logic [30:0]       rhs;
    logic [62:0]       power;
    logic signed [63:0] raw;
  } in_word_t;

  typedef struct packed {
    logic [30:0] value;
    logic        equal;
  } out_word_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_ZERO,
    CMD_DIV_A,
    CMD_DIV_B,
    CMD_DIV_P,
    CMD_DIV_RAW,
    CMD_DIV_EU,
    CMD_STEP,
    CMD_WB_A,
    CMD_WB_B,
    CMD_WB_ACC,
    CMD_WB_BASE,
    CMD_WB_SIGNED,
    CMD_MUL_AB,
    CMD_MUL_AA,
    CMD_MUL_ACC,
    CMD_MUL_NU,
    CMD_EU_INIT,
    CMD_EU_MUL,
    CMD_EU_UPD,
    CMD_SET_ONE,
    CMD_ADD,
    CMD_SUB,
    CMD_NEG,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic       mzero;
    logic [2:0] mode;
    logic       e_zero;
    logic       e_lsb;
    logic       eb_zero;
    logic       div_busy;
  } pfau_status_t;

endpackage

@@ src/pfau_datapath.sv @@
module pfau_datapath
  import pfau_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  in_word_t         in_data,
  input  logic [MOD_W-1:0] modulus,
  output pfau_status_t     status,
  output out_word_t        out_data
);

  logic [2:0]         mode_r;
  logic [30:0]        a_r, b_r, acc_r;
  logic [62:0]        e_r;
  logic [63:0]        raw_r;
  logic               eq_r;
  logic [63:0]        x_r;
  logic [30:0]        rem_r, d_r;
  logic [6:0]         cnt_r;
  logic               neg_r;
  logic [63:0]        p_r;
  logic [30:0]        ea_r, eb_r;
  logic signed [32:0] u_r, v_r, t_r;
  out_word_t          out_r;

  logic [31:0]        rem_sh, rem_diff, sum, m32, sub_res;
  logic               fits;
  logic [30:0]        rem_step;
  logic [63:0]        raw_mag;
  logic [32:0]        u_mag;
  logic signed [32:0] qv;
  logic [30:0]        mul_l;
  logic [32:0]        mul_r;
  logic [63:0]        mul_p;

  // Restoring division: the dividend shifts out of x_r while quotient bits shift in.
  assign rem_sh   = {rem_r, x_r[63]};
  assign rem_diff = rem_sh - {1'b0, d_r};
  assign fits     = rem_sh >= {1'b0, d_r};
  assign rem_step = fits ? rem_diff[30:0] : rem_sh[30:0];

  assign m32     = {1'b0, modulus};
  assign sum     = {1'b0, a_r} + {1'b0, b_r};
  assign sub_res = (a_r >= b_r) ? ({1'b0, a_r} - {1'b0, b_r})
                                : (sum - {1'b0, b_r} + m32 - {1'b0, b_r});
  assign raw_mag = raw_r[63] ? (64'd0 - raw_r) : raw_r;
  assign u_mag   = u_r[32] ? 33'(-u_r) : 33'(u_r);
  // Only the low 33 bits are kept; the Bezout coefficients never exceed them.
  assign qv      = $signed({2'b00, x_r[30:0]}) * v_r;

  always_comb begin
    mul_l = a_r;
    mul_r = {2'b00, b_r};
    case (cmd)
      CMD_MUL_AA:  mul_r = {2'b00, a_r};
      CMD_MUL_ACC: begin
        mul_l = acc_r;
        mul_r = {2'b00, a_r};
      end
      CMD_MUL_NU:  mul_r = u_mag;
      default: ;
    endcase
  end
  assign mul_p = 64'(mul_l) * 64'(mul_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      unique case (cmd) inside
        CMD_DIV_A, CMD_DIV_B, CMD_DIV_P, CMD_DIV_RAW, CMD_DIV_EU: cnt_r <= DIV_STEPS;
        CMD_STEP: cnt_r <= cnt_r - 7'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd) inside
      CMD_LOAD: begin
        mode_r <= in_data.mode;
        a_r    <= in_data.lhs;
        b_r    <= in_data.rhs;
        e_r    <= in_data.power;
        raw_r  <= in_data.raw;
        eq_r   <= (in_data.lhs == in_data.rhs);
      end
      CMD_ZERO: acc_r <= '0;
      CMD_DIV_A: begin
        x_r <= {33'd0, a_r}; rem_r <= '0; d_r <= modulus;
      end
      CMD_DIV_B: begin
        x_r <= {33'd0, b_r}; rem_r <= '0; d_r <= modulus;
      end
      CMD_DIV_P: begin
        x_r <= p_r; rem_r <= '0; d_r <= modulus;
      end
      CMD_DIV_RAW: begin
        x_r <= raw_mag; rem_r <= '0; d_r <= modulus; neg_r <= raw_r[63];
      end
      CMD_DIV_EU: begin
        x_r <= {33'd0, ea_r}; rem_r <= '0; d_r <= eb_r;
      end
      CMD_STEP: begin
        rem_r <= rem_step;
        x_r   <= {x_r[62:0], fits};
      end
      CMD_WB_A:   a_r <= rem_r;
      CMD_WB_B: begin
        b_r  <= rem_r;
        eq_r <= (a_r == rem_r);
      end
      CMD_WB_ACC: acc_r <= rem_r;
      CMD_WB_BASE: begin
        a_r <= rem_r;
        e_r <= {1'b0, e_r[62:1]};
      end
      CMD_WB_SIGNED: acc_r <= (neg_r && rem_r != '0) ? (modulus - rem_r) : rem_r;
      CMD_MUL_AB, CMD_MUL_AA, CMD_MUL_ACC: begin
        p_r <= mul_p; neg_r <= 1'b0;
      end
      CMD_MUL_NU: begin
        p_r <= mul_p; neg_r <= u_r[32];
      end
      CMD_EU_INIT: begin
        ea_r <= b_r; eb_r <= modulus; u_r <= 33'sd1; v_r <= 33'sd0;
      end
      CMD_EU_MUL: begin
        t_r  <= qv;
        ea_r <= eb_r;
        eb_r <= rem_r;
      end
      CMD_EU_UPD: begin
        u_r <= v_r;
        v_r <= u_r - t_r;
      end
      CMD_SET_ONE: acc_r <= (modulus == 31'd1) ? 31'd0 : 31'd1;
      CMD_ADD:     acc_r <= (sum >= m32) ? 31'(sum - m32) : sum[30:0];
      CMD_SUB:     acc_r <= sub_res[30:0];
      CMD_NEG:     acc_r <= (a_r != '0) ? (modulus - a_r) : '0;
      CMD_OUT: begin
        out_r.value <= acc_r;
        out_r.equal <= eq_r;
      end
      default: ;
    endcase
  end

  assign status.mzero    = (modulus == '0);
  assign status.mode     = mode_r;
  assign status.e_zero   = (e_r == '0);
  assign status.e_lsb    = e_r[0];
  assign status.eb_zero  = (eb_r == '0);
  assign status.div_busy = (cnt_r != '0);
  assign out_data        = out_r;

endmodule

@@ src/pfau_ctrl.sv @@
module pfau_ctrl
  import pfau_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  pfau_status_t status,
  output cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_DIVW, S_WBA, S_STB, S_WBB, S_DISP, S_MULR, S_WACC, S_WSGN,
    S_PLOOP, S_PM, S_PMWB, S_PSQ, S_PSD, S_PSWB, S_ELOOP, S_EM, S_EU, S_EN, S_FIN
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd       = CMD_NOP;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd = CMD_LOAD; state_nxt = S_CHK;
      end
      S_CHK: begin
        if (status.mzero) begin
          cmd = CMD_ZERO; state_nxt = S_FIN;
        end else begin
          cmd = CMD_DIV_A; ret_nxt = S_WBA; state_nxt = S_DIVW;
        end
      end
      S_DIVW: begin
        if (status.div_busy) cmd = CMD_STEP;
        else state_nxt = ret_r;
      end
      S_WBA: begin
        cmd = CMD_WB_A; state_nxt = S_STB;
      end
      S_STB: begin
        cmd = CMD_DIV_B; ret_nxt = S_WBB; state_nxt = S_DIVW;
      end
      S_WBB: begin
        cmd = CMD_WB_B; state_nxt = S_DISP;
      end
      S_DISP: begin
        unique case (status.mode)
          MODE_ADD: begin cmd = CMD_ADD; state_nxt = S_FIN; end
          MODE_SUB: begin cmd = CMD_SUB; state_nxt = S_FIN; end
          MODE_NEG: begin cmd = CMD_NEG; state_nxt = S_FIN; end
          MODE_MUL: begin cmd = CMD_MUL_AB; state_nxt = S_MULR; end
          MODE_DIV: begin cmd = CMD_EU_INIT; state_nxt = S_ELOOP; end
          MODE_POW: begin cmd = CMD_SET_ONE; state_nxt = S_PLOOP; end
          MODE_RED: begin
            cmd = CMD_DIV_RAW; ret_nxt = S_WSGN; state_nxt = S_DIVW;
          end
          default: begin cmd = CMD_ZERO; state_nxt = S_FIN; end
        endcase
      end
      S_MULR: begin
        cmd = CMD_DIV_P; ret_nxt = S_WACC; state_nxt = S_DIVW;
      end
      S_WACC: begin
        cmd = CMD_WB_ACC; state_nxt = S_FIN;
      end
      S_WSGN: begin
        cmd = CMD_WB_SIGNED; state_nxt = S_FIN;
      end
      // Square-and-multiply, least significant exponent bit first.
      S_PLOOP: begin
        if (status.e_zero) state_nxt = S_FIN;
        else if (status.e_lsb) begin
          cmd = CMD_MUL_ACC; state_nxt = S_PM;
        end else state_nxt = S_PSQ;
      end
      S_PM: begin
        cmd = CMD_DIV_P; ret_nxt = S_PMWB; state_nxt = S_DIVW;
      end
      S_PMWB: begin
        cmd = CMD_WB_ACC; state_nxt = S_PSQ;
      end
      S_PSQ: begin
        cmd = CMD_MUL_AA; state_nxt = S_PSD;
      end
      S_PSD: begin
        cmd = CMD_DIV_P; ret_nxt = S_PSWB; state_nxt = S_DIVW;
      end
      S_PSWB: begin
        cmd = CMD_WB_BASE; state_nxt = S_PLOOP;
      end
      // Extended Euclid: one quotient per pass, then the coefficient update.
      S_ELOOP: begin
        if (status.eb_zero) begin
          cmd = CMD_MUL_NU; state_nxt = S_EN;
        end else begin
          cmd = CMD_DIV_EU; ret_nxt = S_EM; state_nxt = S_DIVW;
        end
      end
      S_EM: begin
        cmd = CMD_EU_MUL; state_nxt = S_EU;
      end
      S_EU: begin
        cmd = CMD_EU_UPD; state_nxt = S_ELOOP;
      end
      S_EN: begin
        cmd = CMD_DIV_P; ret_nxt = S_WSGN; state_nxt = S_DIVW;
      end
      S_FIN: if (!out_valid_r || !out_stall) begin
        cmd = CMD_OUT; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd == CMD_OUT) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ src/prime_field_arithmetic_unit.sv @@
// Arithmetic over the integers modulo a prime held in the modulus register (reset
// 1000000007). One word is worked on at a time; in_stall stays high until the result
// has been moved to the output register, which lets a new word in while the result
// waits. All cost comes from one shared bit-serial remainder unit, fed by a 31x33
// multiplier, with a second multiplier for the Euclid coefficients. Add, subtract
// and negate cost least, multiply and reduce more; divide grows with the number of
// Euclid steps, and power with the exponent bits, a set bit costing more than a
// clear one. Change the modulus only while no word is in flight.
module prime_field_arithmetic_unit
  import pfau_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [MOD_W-1:0] cfg_data
);

  logic [MOD_W-1:0] modulus_r;
  pfau_status_t     status;
  cmd_t             cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
    end else if (cfg_valid) begin
      modulus_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  pfau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pfau_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .modulus  (modulus_r),
    .status   (status),
    .out_data (out_data)
  );

endmodule

@@ verif/prime_field_arithmetic_unit_test.sv @@
module prime_field_arithmetic_unit_test;
  import pfau_pkg::*;

  localparam logic [2:0] MODE_SPARE = 3'd7;
  localparam int LONG_HOLD_CYCLES = 2000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_word_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_word_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [MOD_W-1:0] cfg_data;

  logic [MOD_W-1:0] field_modulus;
  out_word_t        pending_results[$];
  int               mismatch_count;
  int               stray_count;
  int               words_sent;
  int               words_checked;
  int               mode_seen[8];
  int               moduli_used;
  bit               quiet;
  bit               hold_request;

  prime_field_arithmetic_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    #400_000_000;
    $display("timeout: %0d words still awaited", pending_results.size());
    $display("simulation failed");
    $finish;
  end

  // Field arithmetic as the unit should perform it under modulus m.
  function automatic out_word_t field_result(in_word_t w, logic [MOD_W-1:0] m);
    out_word_t        r;
    longint unsigned  mm, a, b, e, base, acc, raw, res;
    longint           ea, eb, eu, ev, q, t, sr;
    mm = m;
    a = w.lhs;
    b = w.rhs;
    res = 0;
    if (mm == 0) begin
      r.value = '0;
      r.equal = (a == b);
      return r;
    end
    a = a % mm;
    b = b % mm;
    case (w.mode)
      MODE_ADD: begin
        res = a + b;
        if (res >= mm) res = res - mm;
      end
      MODE_SUB: res = (a >= b) ? a - b : a + mm - b;
      MODE_MUL: res = (a * b) % mm;
      MODE_DIV: begin
        ea = b;
        eb = mm;
        eu = 1;
        ev = 0;
        while (eb != 0) begin
          q = ea / eb;
          ea = ea - q * eb;
          t = ea; ea = eb; eb = t;
          eu = eu - q * ev;
          t = eu; eu = ev; ev = t;
        end
        sr = (longint'(a) * eu) % longint'(mm);
        if (sr < 0) sr = sr + longint'(mm);
        res = sr;
      end
      MODE_NEG: res = (a != 0) ? mm - a : 0;
      MODE_POW: begin
        acc = 1 % mm;
        base = a;
        e = w.power;
        while (e != 0) begin
          if (e[0]) acc = (acc * base) % mm;
          base = (base * base) % mm;
          e = e >> 1;
        end
        res = acc;
      end
      MODE_RED: begin
        raw = w.raw;
        if (raw[63]) begin
          res = (64'd0 - raw) % mm;
          res = (res != 0) ? mm - res : 0;
        end else begin
          res = raw % mm;
        end
      end
      default: res = 0;
    endcase
    r.value = res[30:0];
    r.equal = (a == b);
    return r;
  endfunction

  function automatic in_word_t make_word(logic [2:0] mode, logic [30:0] lhs, logic [30:0] rhs,
                                         logic [62:0] power, logic [63:0] raw);
    in_word_t w;
    w.mode = mode;
    w.lhs = lhs;
    w.rhs = rhs;
    w.power = power;
    w.raw = raw;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w.mode = 3'($urandom_range(0, 7));
    w.lhs = 31'($urandom);
    w.rhs = ($urandom_range(0, 9) == 0) ? w.lhs : 31'($urandom);
    // Wide exponents are slow, so most stay within a byte.
    if ($urandom_range(0, 39) == 0) w.power = 63'({$urandom, $urandom});
    else w.power = 63'($urandom_range(0, 255));
    w.raw = {$urandom, $urandom};
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results = {pending_results, field_result(w, field_modulus)};
    words_sent++;
    mode_seen[w.mode]++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic set_modulus(logic [MOD_W-1:0] m);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    field_modulus = m;
    moduli_used++;
  endtask

  task automatic test_directed_words();
    send_word(make_word(MODE_ADD, 31'd1000000006, 31'd1000000006, '0, '0));
    send_word(make_word(MODE_ADD, 31'h7FFFFFFF, 31'd0, '0, '0));
    send_word(make_word(MODE_SUB, 31'd0, 31'd1000000006, '0, '0));
    send_word(make_word(MODE_SUB, 31'h7FFFFFFF, 31'h7FFFFFFF, '0, '0));
    send_word(make_word(MODE_MUL, 31'd1000000006, 31'd1000000006, '0, '0));
    send_word(make_word(MODE_MUL, 31'h7FFFFFFF, 31'h7FFFFFFE, '0, '0));
    send_word(make_word(MODE_DIV, 31'd12345, 31'd0, '0, '0));
    send_word(make_word(MODE_DIV, 31'd1, 31'd1000000006, '0, '0));
    send_word(make_word(MODE_DIV, 31'h7FFFFFFF, 31'd3, '0, '0));
    send_word(make_word(MODE_NEG, 31'd0, 31'd5, '0, '0));
    send_word(make_word(MODE_NEG, 31'd1000000006, 31'd5, '0, '0));
    send_word(make_word(MODE_POW, 31'd0, 31'd0, 63'd0, '0));
    send_word(make_word(MODE_POW, 31'd2, 31'd1, '1, '0));
    send_word(make_word(MODE_POW, 31'd1000000006, 31'd1, 63'd1, '0));
    send_word(make_word(MODE_RED, 31'd0, 31'd0, '0, 64'h8000000000000000));
    send_word(make_word(MODE_RED, 31'd0, 31'd0, '0, 64'h7FFFFFFFFFFFFFFF));
    send_word(make_word(MODE_RED, 31'd0, 31'd0, '0, '1));
    send_word(make_word(MODE_RED, 31'd0, 31'd0, '0, 64'd1000000007));
    send_word(make_word(MODE_SPARE, 31'd9, 31'd9, '1, '1));
  endtask

  // Degenerate and composite moduli, where the field rules no longer hold.
  task automatic test_special_moduli();
    logic [MOD_W-1:0] odd_moduli[3];
    odd_moduli = '{31'd0, 31'd1, 31'd1000000};
    foreach (odd_moduli[i]) begin
      set_modulus(odd_moduli[i]);
      for (int mode = 0; mode < 8; mode++)
        send_word(make_word(3'(mode), 31'd123456, 31'd123456, 63'(mode), -64'sd77));
      send_word(make_word(MODE_DIV, 31'd7, 31'd250, '0, '0));
      send_word(make_word(MODE_POW, 31'd5, 31'd3, 63'd0, '0));
    end
  endtask

  task automatic test_random_words(logic [MOD_W-1:0] m, int count);
    set_modulus(m);
    repeat (count) send_word(random_word());
  endtask

  // The receiver stops for a long stretch while words keep coming.
  task automatic test_output_hold();
    hold_request = 1'b1;
    repeat (12) send_word(random_word());
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        stray_count++;
        $display("unexpected result word value=%0d equal=%0b", out_data.value, out_data.equal);
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (out_data.value !== want.value || out_data.equal !== want.equal) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected value=%0d equal=%0b, got value=%0d equal=%0b",
                     want.value, want.equal, out_data.value, out_data.equal);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    field_modulus = MOD_RESET;
    quiet = 1'b0;
    hold_request = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_words();
    test_special_moduli();
    test_random_words(31'd2147483647, 250);
    test_output_hold();
    test_random_words(31'd2, 200);
    test_random_words(31'd7, 200);
    test_random_words(31'd65537, 250);
    test_random_words(31'd999983, 200);
    test_random_words(31'd1000000007, 250);
    quiet = 1'b1;
    test_random_words(31'd2147483629, 250);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("covered %0d words (%0d checked) under %0d moduli, including zero, one and a composite",
             words_sent, words_checked, moduli_used);
    $display("words per mode: %0d %0d %0d %0d %0d %0d %0d %0d", mode_seen[0], mode_seen[1],
             mode_seen[2], mode_seen[3], mode_seen[4], mode_seen[5], mode_seen[6], mode_seen[7]);
    if (mismatch_count == 0 && stray_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d unexpected words", mismatch_count, stray_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ prime_field_arithmetic_unit.f @@
src/pfau_pkg.sv
src/pfau_datapath.sv
src/pfau_ctrl.sv
src/prime_field_arithmetic_unit.sv
verif/prime_field_arithmetic_unit_test.sv
